FILE: rtl/core/dqs_pkg.sv
// Shared types and codes for the deque with shell-sort insertion step.
// Used by dqs_core and the top level deque_with_shell_sort_step; no dependencies.
package dqs_pkg;

	// Field widths of the request and response words
	localparam int ACTION_W = 3;
	localparam int KEY_W    = 16;
	localparam int POS_W    = 5;
	localparam int FILL_W   = 6;
	localparam int STATUS_W = 2;

	typedef logic [ACTION_W-1:0] action_t;
	typedef logic [STATUS_W-1:0] status_t;

	// Action codes
	localparam action_t ACT_PUSH_BACK  = 3'd0;
	localparam action_t ACT_PUSH_FRONT = 3'd1;
	localparam action_t ACT_POP_FRONT  = 3'd2;
	localparam action_t ACT_POP_BACK   = 3'd3;
	localparam action_t ACT_PEEK       = 3'd4;
	localparam action_t ACT_READ       = 3'd5;
	localparam action_t ACT_CLEAR      = 3'd6;
	localparam action_t ACT_SHELL      = 3'd7;

	// Status codes
	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_FULL      = 2'd1;
	localparam status_t ST_EMPTY     = 2'd2;
	localparam status_t ST_BAD_INDEX = 2'd3;

	// One response word, handed from the core to the output stage
	typedef struct packed {
		logic [KEY_W-1:0]  key_out;
		logic [FILL_W-1:0] fill;
		status_t           status;
		logic              moved;
	} dqs_result_t;

endpackage

FILE: rtl/core/dqs_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module dqs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/core/dqs_core.sv
// Deque control: head pointer, occupancy, action decode and the shell-step walker.
// Depends on dqs_pkg; drives the key memory (dqs_ram) held by the top level.
module dqs_core #(
	parameter int CAPACITY = 32,
	parameter int KEY_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// request word
	input  logic                                  req_valid,
	output logic                                  req_ready,
	input  dqs_pkg::action_t                      action,
	input  logic [dqs_pkg::KEY_W-1:0]             key_in,
	input  logic [dqs_pkg::POS_W-1:0]             position,
	input  logic [dqs_pkg::POS_W-1:0]             gap,
	// result word
	output logic                                  res_valid,
	input  logic                                  res_ready,
	output dqs_pkg::dqs_result_t                  res,
	// key memory
	output logic                                  ram_wr_en,
	output logic [$clog2(CAPACITY)-1:0]           ram_wr_addr,
	output logic [((KEY_BITS < dqs_pkg::KEY_W) ? KEY_BITS : dqs_pkg::KEY_W)-1:0] ram_wr_data,
	output logic                                  ram_rd_en,
	output logic [$clog2(CAPACITY)-1:0]           ram_rd_addr,
	input  logic [((KEY_BITS < dqs_pkg::KEY_W) ? KEY_BITS : dqs_pkg::KEY_W)-1:0] ram_rd_data
);

	localparam int AW      = $clog2(CAPACITY);
	localparam int OW      = $clog2(CAPACITY + 1);
	localparam int STORE_W = (KEY_BITS < dqs_pkg::KEY_W) ? KEY_BITS : dqs_pkg::KEY_W;
	localparam int LW      = (OW > dqs_pkg::POS_W + 1) ? OW : dqs_pkg::POS_W + 1;
	localparam int SW      = LW + 1;
	localparam int CW      = (OW > dqs_pkg::POS_W) ? OW : dqs_pkg::POS_W;

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_TAKE = 3'd2;
	localparam logic [2:0] S_CMP  = 3'd3;
	localparam logic [2:0] S_PUT  = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0]                 state_q, state_d;
	logic [AW-1:0]              head_q;
	logic [OW-1:0]              occ_q;
	logic [STORE_W-1:0]         taken_q;
	logic [dqs_pkg::POS_W-1:0]  j_q;
	logic [dqs_pkg::POS_W-1:0]  gap_q;
	dqs_pkg::dqs_result_t       res_q;

	logic                       accept;
	logic                       full;
	logic                       empty;
	logic                       pos_bad;
	dqs_pkg::status_t           req_status;
	logic [OW-1:0]              occ_nxt;
	logic [AW-1:0]              head_dec;
	logic [AW-1:0]              head_inc;
	logic                       j_ge_gap;
	logic                       larger;

	// logical index to ring slot; callers keep the index below CAPACITY
	function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] hd, input logic [LW-1:0] lg);
		logic [SW-1:0] sum;
		sum = SW'(hd) + SW'(lg);
		if (sum >= SW'(CAPACITY)) begin
			sum = sum - SW'(CAPACITY);
		end
		return sum[AW-1:0];
	endfunction

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid & req_ready;
	assign full      = (occ_q == OW'(CAPACITY));
	assign empty     = (occ_q == '0);
	assign pos_bad   = (CW'(position) >= CW'(occ_q));
	assign head_dec  = (head_q == '0) ? AW'(CAPACITY - 1) : head_q - AW'(1);
	assign head_inc  = (head_q == AW'(CAPACITY - 1)) ? '0 : head_q + AW'(1);
	assign j_ge_gap  = (j_q >= gap_q);
	assign larger    = (ram_rd_data > taken_q);

	// request check and occupancy after the action
	always_comb begin
		req_status = dqs_pkg::ST_OK;
		occ_nxt    = occ_q;
		unique case (action)
			dqs_pkg::ACT_PUSH_BACK, dqs_pkg::ACT_PUSH_FRONT: begin
				if (full) begin
					req_status = dqs_pkg::ST_FULL;
				end else begin
					occ_nxt = occ_q + OW'(1);
				end
			end
			dqs_pkg::ACT_POP_FRONT, dqs_pkg::ACT_POP_BACK: begin
				if (empty) begin
					req_status = dqs_pkg::ST_EMPTY;
				end else begin
					occ_nxt = occ_q - OW'(1);
				end
			end
			dqs_pkg::ACT_PEEK: begin
				if (empty) begin
					req_status = dqs_pkg::ST_EMPTY;
				end
			end
			dqs_pkg::ACT_READ: begin
				if (pos_bad) begin
					req_status = dqs_pkg::ST_BAD_INDEX;
				end
			end
			dqs_pkg::ACT_CLEAR: begin
				occ_nxt = '0;
			end
			dqs_pkg::ACT_SHELL: begin
				if (pos_bad || gap == '0) begin
					req_status = dqs_pkg::ST_BAD_INDEX;
				end
			end
			default: ;
		endcase
	end

	// memory port control
	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = head_q;
		ram_wr_data = key_in[STORE_W-1:0];
		ram_rd_en   = 1'b0;
		ram_rd_addr = head_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && req_status == dqs_pkg::ST_OK) begin
					case (action)
						dqs_pkg::ACT_PUSH_BACK: begin
							ram_wr_en   = 1'b1;
							ram_wr_addr = slot_of(head_q, LW'(occ_q));
						end
						dqs_pkg::ACT_PUSH_FRONT: begin
							ram_wr_en   = 1'b1;
							ram_wr_addr = head_dec;
						end
						dqs_pkg::ACT_PEEK: begin
							ram_rd_en = 1'b1;
						end
						dqs_pkg::ACT_READ, dqs_pkg::ACT_SHELL: begin
							ram_rd_en   = 1'b1;
							ram_rd_addr = slot_of(head_q, LW'(position));
						end
						default: ;
					endcase
				end
			end
			S_TAKE: begin
				// first comparison partner at position - gap
				if (j_ge_gap) begin
					ram_rd_en   = 1'b1;
					ram_rd_addr = slot_of(head_q, LW'(j_q - gap_q));
				end
			end
			S_CMP: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = slot_of(head_q, LW'(j_q) + LW'(gap_q));
				if (larger) begin
					// shift this key one gap toward the tail, fetch the next one down
					ram_wr_data = ram_rd_data;
					if (j_ge_gap) begin
						ram_rd_en   = 1'b1;
						ram_rd_addr = slot_of(head_q, LW'(j_q - gap_q));
					end
				end else begin
					ram_wr_data = taken_q;
				end
			end
			S_PUT: begin
				// walk ran off the front: taken key lands at the last hole
				ram_wr_en   = 1'b1;
				ram_wr_addr = slot_of(head_q, LW'(j_q));
				ram_wr_data = taken_q;
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req_status != dqs_pkg::ST_OK) begin
						state_d = S_DONE;
					end else if (action == dqs_pkg::ACT_PEEK || action == dqs_pkg::ACT_READ) begin
						state_d = S_READ;
					end else if (action == dqs_pkg::ACT_SHELL) begin
						state_d = S_TAKE;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_READ: state_d = S_DONE;
			S_TAKE: state_d = j_ge_gap ? S_CMP : S_DONE;
			S_CMP: begin
				if (!larger) begin
					state_d = S_DONE;
				end else if (!j_ge_gap) begin
					state_d = S_PUT;
				end
			end
			S_PUT: state_d = S_DONE;
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			occ_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept && req_status == dqs_pkg::ST_OK) begin
				occ_q <= occ_nxt;
				case (action)
					dqs_pkg::ACT_PUSH_FRONT: head_q <= head_dec;
					dqs_pkg::ACT_POP_FRONT:  head_q <= head_inc;
					dqs_pkg::ACT_CLEAR:      head_q <= '0;
					default: ;
				endcase
			end
		end
	end

	// walker and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					res_q.key_out <= '0;
					res_q.fill    <= dqs_pkg::FILL_W'(occ_nxt);
					res_q.status  <= req_status;
					res_q.moved   <= 1'b0;
					j_q           <= position;
					gap_q         <= gap;
				end
			end
			S_READ: begin
				res_q.key_out <= dqs_pkg::KEY_W'(ram_rd_data);
			end
			S_TAKE: begin
				taken_q <= ram_rd_data;
				if (j_ge_gap) begin
					j_q <= j_q - gap_q;
				end
			end
			S_CMP: begin
				if (larger) begin
					res_q.moved <= 1'b1;
					if (j_ge_gap) begin
						j_q <= j_q - gap_q;
					end
				end
			end
			default: ;
		endcase
	end

	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

endmodule

FILE: rtl/core/deque_with_shell_sort_step.sv
// Bounded deque of keys with a shell-sort gapped insertion step. One request word is
// taken at a time. Push, pop and clear go straight to the response; peek and read first
// wait for a registered memory read; a shell step reads the key at position, compares
// keys (at most position / gap), and writes once more when the walk reaches the front
// of the queue; the key memory allows one read and one write per cycle, so the walk
// moves one entry per cycle. A response waits in an output register, so the next
// request can be taken before it is drained. Depends on dqs_pkg, dqs_core and dqs_ram.
module deque_with_shell_sort_step #(
	parameter int CAPACITY = 32,
	parameter int KEY_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  dqs_pkg::action_t                 action,
	input  logic [dqs_pkg::KEY_W-1:0]        key_in,
	input  logic [dqs_pkg::POS_W-1:0]        position,
	input  logic [dqs_pkg::POS_W-1:0]        gap,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output logic [dqs_pkg::KEY_W-1:0]        key_out,
	output logic [dqs_pkg::FILL_W-1:0]       fill,
	output dqs_pkg::status_t                 status,
	output logic                             moved
);

	localparam int AW      = $clog2(CAPACITY);
	localparam int STORE_W = (KEY_BITS < dqs_pkg::KEY_W) ? KEY_BITS : dqs_pkg::KEY_W;

	logic                 ram_wr_en;
	logic [AW-1:0]        ram_wr_addr;
	logic [STORE_W-1:0]   ram_wr_data;
	logic                 ram_rd_en;
	logic [AW-1:0]        ram_rd_addr;
	logic [STORE_W-1:0]   ram_rd_data;

	logic                 res_valid;
	logic                 res_ready;
	dqs_pkg::dqs_result_t res;
	logic                 load;

	logic                 out_valid_q;
	dqs_pkg::dqs_result_t out_q;

	// key store
	dqs_ram #(
		.WIDTH(STORE_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_en  (ram_rd_en),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	// control and shell-step walker
	dqs_core #(
		.CAPACITY(CAPACITY),
		.KEY_BITS(KEY_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.action     (action),
		.key_in     (key_in),
		.position   (position),
		.gap        (gap),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.ram_wr_en  (ram_wr_en),
		.ram_wr_addr(ram_wr_addr),
		.ram_wr_data(ram_wr_data),
		.ram_rd_en  (ram_rd_en),
		.ram_rd_addr(ram_rd_addr),
		.ram_rd_data(ram_rd_data)
	);

	// output register: takes a new word when empty or being drained
	assign res_ready = !out_valid_q || rsp_ready;
	assign load      = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= res;
		end
	end

	assign rsp_valid = out_valid_q;
	assign key_out   = out_q.key_out;
	assign fill      = out_q.fill;
	assign status    = out_q.status;
	assign moved     = out_q.moved;

endmodule
